// ===== hw/rtl/gti_pkg.sv =====
// Shared types, codes and the Q1.16 blend function for the grid interpolator.
// No dependencies.
package gti_pkg;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] KIND_LOAD_ENERGY = 3'd0;
    localparam logic [2:0] KIND_LOAD_DMSQ   = 3'd1;
    localparam logic [2:0] KIND_LOAD_THETA  = 3'd2;
    localparam logic [2:0] KIND_LOAD_PROB   = 3'd3;
    localparam logic [2:0] KIND_QUERY       = 3'd4;

    localparam logic [1:0] CFG_ENERGY_POINTS = 2'd0;
    localparam logic [1:0] CFG_DMSQ_POINTS   = 2'd1;
    localparam logic [1:0] CFG_THETA_POINTS  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ENERGY_OOR = 2'd1,
        ST_DMSQ_OOR   = 2'd2,
        ST_THETA_OOR  = 2'd3
    } status_t;

    // (p0*(1-f) + p1*f) with round half up, all Q1.16
    function automatic logic [16:0] lerp_q16(input logic [16:0] p0,
                                            input logic [16:0] p1,
                                            input logic [16:0] f);
        logic [17:0] g;
        logic [34:0] s;
        begin
            g = {1'b0, ONE_Q16} - {1'b0, f};
            s = 35'(p0) * 35'(g) + 35'(p1) * 35'(f) + 35'd32768;
            return s[32:16];
        end
    endfunction

endpackage

// ===== hw/rtl/grid_trilinear_interpolator_core.sv =====
// Trilinear interpolator over a rectilinear grid held in on-chip memories.
// Depends on gti_pkg.
//
// Usage:
//  - Items arrive on start/kind/... and are taken when start is high and busy
//    is low. Kinds 0..2 write an axis entry, kind 3 writes a probability
//    (saturated at 1.0), kind 4 is a query; kinds 5..7 are dropped.
//  - Loads finish in the cycle they are taken; busy stays low.
//  - A query raises busy until its result is shown: probability and status
//    are valid for exactly one cycle while done is high. The receiver cannot
//    stall, so the result is simply presented and dropped.
//  - Per axis a query runs a range check (reads of the first and last entry),
//    a binary search (a read and a compare per step, plus a closing read) and
//    a bit-serial fraction division (a setup step for the integer bit, then
//    16 quotient bits, cut short when the bracket is flat), all through the
//    single read port of that axis memory. Then the plane stride is formed,
//    and for each of four (dmsq, theta) corners an address, two energy reads
//    and an energy blend follow; dmsq and theta blends end the query. done
//    rises as busy falls, and a new item can already be taken in that cycle.
//    An out-of-range query ends right after the check of its failing axis.
//  - Configuration (points used per axis) goes over cfg_valid/cfg_ready,
//    always ready; user sends it only while the block is idle (unenforced).
//  - Reset clears control state and the configuration to full tables;
//    table contents are undefined until loaded.
module grid_trilinear_interpolator_core
    import gti_pkg::*;
#(
    parameter int ENERGY_MAX_POINTS = 128,
    parameter int DMSQ_MAX_POINTS   = 32,
    parameter int THETA_MAX_POINTS  = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [16:0] load_index,
    input  logic [31:0] load_value,
    input  logic [31:0] energy_coord,
    input  logic [31:0] dmsq_coord,
    input  logic [31:0] theta_coord,
    output logic        done,
    output logic [16:0] probability,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int PROB_DEPTH = ENERGY_MAX_POINTS * DMSQ_MAX_POINTS * THETA_MAX_POINTS;
    localparam int EW   = $clog2(ENERGY_MAX_POINTS);
    localparam int DW   = $clog2(DMSQ_MAX_POINTS);
    localparam int TW   = $clog2(THETA_MAX_POINTS);
    localparam int ECW  = $clog2(ENERGY_MAX_POINTS + 1);
    localparam int TCW  = $clog2(THETA_MAX_POINTS + 1);
    localparam int PAW  = $clog2(PROB_DEPTH);
    localparam int AXW  = (EW > DW) ? ((EW > TW) ? EW : TW) : ((DW > TW) ? DW : TW);
    localparam int AXCW = AXW + 1;
    localparam int NTW  = ECW + TCW;
    localparam int PRW  = NTW + DW;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_CHK, S_SRCH_RD, S_SRCH_CMP, S_DIV_INIT, S_DIV,
        S_NENT, S_C_ADR, S_C_RD0, S_C_RD1, S_C_LERP_E, S_C_LERP_D, S_C_LERP_T
    } state_t;

    // ---------------- configuration ----------------
    logic [7:0] energy_pts_reg;
    logic [5:0] dmsq_pts_reg;
    logic [5:0] theta_pts_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_pts_reg <= 8'd128;
            dmsq_pts_reg   <= 6'd32;
            theta_pts_reg  <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENERGY_POINTS: energy_pts_reg <= cfg_data;
                CFG_DMSQ_POINTS:   dmsq_pts_reg   <= cfg_data[5:0];
                CFG_THETA_POINTS:  theta_pts_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // clamp counts to 2..MAX
    logic [31:0] ne_w, nd_w, nt_w;
    always_comb
    begin
        ne_w = 32'(energy_pts_reg);
        nd_w = 32'(dmsq_pts_reg);
        nt_w = 32'(theta_pts_reg);
        if (ne_w < 32'd2) ne_w = 32'd2;
        if (ne_w > 32'(ENERGY_MAX_POINTS)) ne_w = 32'(ENERGY_MAX_POINTS);
        if (nd_w < 32'd2) nd_w = 32'd2;
        if (nd_w > 32'(DMSQ_MAX_POINTS)) nd_w = 32'(DMSQ_MAX_POINTS);
        if (nt_w < 32'd2) nt_w = 32'd2;
        if (nt_w > 32'(THETA_MAX_POINTS)) nt_w = 32'(THETA_MAX_POINTS);
    end

    // ---------------- control registers ----------------
    state_t           state_reg;
    logic [1:0]       ax_reg;
    logic [31:0]      xe_reg, xd_reg, xt_reg;
    logic [AXCW-1:0]  ne_reg, nd_reg, nt_reg;
    logic [AXW-1:0]   lo_reg, hi_reg;
    logic [31:0]      a_lo_reg, a_hi_reg, first_reg;
    logic [31:0]      rem_reg, den_reg;
    logic [15:0]      q_reg;
    logic [3:0]       cnt_reg;
    logic [EW-1:0]    elo_reg, ehi_reg;
    logic [DW-1:0]    dlo_reg, dhi_reg;
    logic [TW-1:0]    tlo_reg, thi_reg;
    logic [16:0]      fe_reg, fd_reg, ft_reg;
    logic [NTW-1:0]   nent_reg;
    logic [PAW-1:0]   off_reg;
    logic [1:0]       corner_reg;
    logic [16:0]      p0_reg, ed0_reg, ed1_reg, tv0_reg, tv1_reg;
    logic             done_reg;
    logic [16:0]      prob_reg;
    logic [1:0]       status_reg;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // ---------------- memories ----------------
    logic [31:0] energy_mem [ENERGY_MAX_POINTS];
    logic [31:0] dmsq_mem   [DMSQ_MAX_POINTS];
    logic [31:0] theta_mem  [THETA_MAX_POINTS];
    logic [16:0] prob_mem   [PROB_DEPTH];
    logic [31:0] e_rdata, d_rdata, t_rdata;
    logic [16:0] p_rdata;

    logic [31:0]    idx_w;
    logic [16:0]    load_prob;
    logic [AXW-1:0] ax_raddr;
    logic [PAW-1:0] p_raddr;

    assign idx_w     = 32'(load_index);
    assign load_prob = (load_value > 32'(ONE_Q16)) ? ONE_Q16 : load_value[16:0];

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_LOAD_ENERGY && idx_w < 32'(ENERGY_MAX_POINTS))
            energy_mem[idx_w[EW-1:0]] <= load_value;
        e_rdata <= energy_mem[ax_raddr[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_LOAD_DMSQ && idx_w < 32'(DMSQ_MAX_POINTS))
            dmsq_mem[idx_w[DW-1:0]] <= load_value;
        d_rdata <= dmsq_mem[ax_raddr[DW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_LOAD_THETA && idx_w < 32'(THETA_MAX_POINTS))
            theta_mem[idx_w[TW-1:0]] <= load_value;
        t_rdata <= theta_mem[ax_raddr[TW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_LOAD_PROB && idx_w < 32'(PROB_DEPTH))
            prob_mem[idx_w[PAW-1:0]] <= load_prob;
        p_rdata <= prob_mem[p_raddr];
    end

    // ---------------- current-axis selection ----------------
    logic [31:0]     ax_rdata, x_cur;
    logic [AXCW-1:0] n_cur;
    logic [AXW-1:0]  mid_w, last_idx;
    logic [AXW:0]    span_w;

    always_comb
    begin
        case (ax_reg)
            2'd0:    begin ax_rdata = e_rdata; x_cur = xe_reg; n_cur = ne_reg; end
            2'd1:    begin ax_rdata = d_rdata; x_cur = xd_reg; n_cur = nd_reg; end
            default: begin ax_rdata = t_rdata; x_cur = xt_reg; n_cur = nt_reg; end
        endcase
        last_idx = AXW'(n_cur - AXCW'(1));
        span_w   = {1'b0, hi_reg} - {1'b0, lo_reg};
        mid_w    = lo_reg + AXW'(span_w >> 1);
        case (state_reg)
            S_RD0:     ax_raddr = '0;
            S_RD1:     ax_raddr = last_idx;
            S_SRCH_RD: ax_raddr = mid_w;
            default:   ax_raddr = '0;
        endcase
    end

    // corner address: e + t*ne + d*ne*nt
    logic [PRW-1:0] off_w;
    logic [TW-1:0]  t_sel;
    logic [DW-1:0]  d_sel;
    always_comb
    begin
        t_sel = corner_reg[1] ? thi_reg : tlo_reg;
        d_sel = corner_reg[0] ? dhi_reg : dlo_reg;
        off_w = PRW'(t_sel) * PRW'(ne_reg) + PRW'(d_sel) * PRW'(nent_reg);
        if (state_reg == S_C_RD1)
            p_raddr = off_reg + PAW'(ehi_reg);
        else
            p_raddr = off_reg + PAW'(elo_reg);
    end

    // divider step and blends
    logic [31:0] diff_w;
    logic [32:0] r2_w;
    logic        qbit_w;
    logic [16:0] frac_w, lerp_e_w, lerp_d_w, lerp_t_w;
    always_comb
    begin
        diff_w   = x_cur - a_lo_reg;
        r2_w     = {rem_reg, 1'b0};
        qbit_w   = (r2_w >= {1'b0, den_reg});
        frac_w   = ({q_reg, qbit_w} > ONE_Q16) ? ONE_Q16 : {q_reg, qbit_w};
        lerp_e_w = lerp_q16(p0_reg, p_rdata, fe_reg);
        lerp_d_w = lerp_q16(ed0_reg, ed1_reg, fd_reg);
        lerp_t_w = lerp_q16(tv0_reg, tv1_reg, ft_reg);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ax_reg     <= '0;
            done_reg   <= 1'b0;
            prob_reg   <= '0;
            status_reg <= ST_OK;
            xe_reg <= '0; xd_reg <= '0; xt_reg <= '0;
            ne_reg <= '0; nd_reg <= '0; nt_reg <= '0;
            lo_reg <= '0; hi_reg <= '0;
            a_lo_reg <= '0; a_hi_reg <= '0; first_reg <= '0;
            rem_reg <= '0; den_reg <= '0; q_reg <= '0; cnt_reg <= '0;
            elo_reg <= '0; ehi_reg <= '0; dlo_reg <= '0; dhi_reg <= '0;
            tlo_reg <= '0; thi_reg <= '0;
            fe_reg <= '0; fd_reg <= '0; ft_reg <= '0;
            nent_reg <= '0; off_reg <= '0; corner_reg <= '0;
            p0_reg <= '0; ed0_reg <= '0; ed1_reg <= '0; tv0_reg <= '0; tv1_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == KIND_QUERY)
                    begin
                        xe_reg <= energy_coord;
                        xd_reg <= dmsq_coord;
                        xt_reg <= theta_coord;
                        ne_reg <= AXCW'(ne_w);
                        nd_reg <= AXCW'(nd_w);
                        nt_reg <= AXCW'(nt_w);
                        ax_reg <= 2'd0;
                        state_reg <= S_RD0;
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    first_reg <= ax_rdata;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (x_cur >= first_reg && x_cur <= ax_rdata)
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= last_idx;
                        a_lo_reg  <= first_reg;
                        a_hi_reg  <= ax_rdata;
                        state_reg <= S_SRCH_RD;
                    end
                    else
                    begin
                        // first failing axis wins
                        case (ax_reg)
                            2'd0:    status_reg <= ST_ENERGY_OOR;
                            2'd1:    status_reg <= ST_DMSQ_OOR;
                            default: status_reg <= ST_THETA_OOR;
                        endcase
                        prob_reg  <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SRCH_RD:
                begin
                    if (span_w > (AXW+1)'(1))
                    begin
                        state_reg <= S_SRCH_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_SRCH_CMP:
                begin
                    if (ax_rdata <= x_cur)
                    begin
                        lo_reg   <= mid_w;
                        a_lo_reg <= ax_rdata;
                    end
                    else
                    begin
                        hi_reg   <= mid_w;
                        a_hi_reg <= ax_rdata;
                    end
                    state_reg <= S_SRCH_RD;
                end
                S_DIV_INIT:
                begin
                    // x - a_lo never exceeds a_hi - a_lo, so quotient fits 17 bits
                    if (a_hi_reg > a_lo_reg && x_cur >= a_lo_reg)
                    begin
                        den_reg <= a_hi_reg - a_lo_reg;
                        if (diff_w >= (a_hi_reg - a_lo_reg))
                        begin
                            rem_reg <= diff_w - (a_hi_reg - a_lo_reg);
                            q_reg   <= 16'd1;
                        end
                        else
                        begin
                            rem_reg <= diff_w;
                            q_reg   <= 16'd0;
                        end
                        cnt_reg   <= 4'd15;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        den_reg   <= 32'hFFFF_FFFF;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= qbit_w ? 32'(r2_w - {1'b0, den_reg}) : r2_w[31:0];
                    q_reg   <= {q_reg[14:0], qbit_w};
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0)
                    begin
                        case (ax_reg)
                            2'd0:
                            begin
                                elo_reg <= lo_reg[EW-1:0];
                                ehi_reg <= hi_reg[EW-1:0];
                                fe_reg  <= frac_w;
                            end
                            2'd1:
                            begin
                                dlo_reg <= lo_reg[DW-1:0];
                                dhi_reg <= hi_reg[DW-1:0];
                                fd_reg  <= frac_w;
                            end
                            default:
                            begin
                                tlo_reg <= lo_reg[TW-1:0];
                                thi_reg <= hi_reg[TW-1:0];
                                ft_reg  <= frac_w;
                            end
                        endcase
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_NENT;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_RD0;
                        end
                    end
                end
                S_NENT:
                begin
                    nent_reg   <= NTW'(ne_reg) * NTW'(nt_reg);
                    corner_reg <= '0;
                    state_reg  <= S_C_ADR;
                end
                S_C_ADR:
                begin
                    off_reg   <= off_w[PAW-1:0];
                    state_reg <= S_C_RD0;
                end
                S_C_RD0: state_reg <= S_C_RD1;
                S_C_RD1:
                begin
                    p0_reg    <= p_rdata;
                    state_reg <= S_C_LERP_E;
                end
                S_C_LERP_E:
                begin
                    if (!corner_reg[0])
                    begin
                        ed0_reg    <= lerp_e_w;
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= S_C_ADR;
                    end
                    else
                    begin
                        ed1_reg   <= lerp_e_w;
                        state_reg <= S_C_LERP_D;
                    end
                end
                S_C_LERP_D:
                begin
                    if (!corner_reg[1])
                    begin
                        tv0_reg    <= lerp_d_w;
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= S_C_ADR;
                    end
                    else
                    begin
                        tv1_reg   <= lerp_d_w;
                        state_reg <= S_C_LERP_T;
                    end
                end
                S_C_LERP_T:
                begin
                    prob_reg   <= (lerp_t_w > ONE_Q16) ? ONE_Q16 : lerp_t_w;
                    status_reg <= ST_OK;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done        = done_reg;
    assign probability = prob_reg;
    assign status      = status_reg;

    // ---------------- assertions ----------------
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a query in flight");

    a_err_zero_prob: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (probability == '0))
        else $error("error status with nonzero probability");

    a_prob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (probability <= ONE_Q16))
        else $error("probability above one");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY) |=> (busy && !done))
        else $error("query accepted but sequencer not started");

endmodule
